/* src/brc_pkg.sv */
// ----------------------------------------------------------------------------
// brc_pkg: shared types and constants of the rally impact classifier
// Field widths, counter limits, register indexes and the record and bundle
// types passed from the classifier front end to the result sequencer.
// ----------------------------------------------------------------------------
package brc_pkg;

  // field widths
  localparam int X_BITS     = 10;
  localparam int DEPTH_BITS = 16;
  localparam int RALLY_BITS = 8;
  localparam int POS_BITS   = 10;

  // counter saturation limits
  localparam int RALLY_LIMIT = 255;
  localparam int POINT_LIMIT = 1023;

  // results per item and queue size
  localparam int SLOTS       = 3;
  localparam int CNT_BITS    = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = 1;
  localparam int FILL_BITS   = 2;

  // configuration register map
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH_HIGH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH_LOW  = 2'd1;
  localparam logic [DEPTH_BITS-1:0] DEPTH_HIGH_RESET = 16'd2867;
  localparam logic [DEPTH_BITS-1:0] DEPTH_LOW_RESET  = 16'd2458;

  // side codes
  localparam logic SIDE_A = 1'b0;
  localparam logic SIDE_B = 1'b1;

  typedef struct packed {
    logic [DEPTH_BITS-1:0] high;
    logic [DEPTH_BITS-1:0] low;
  } thresholds_t;

  // one result without its end-of-item mark
  typedef struct packed {
    logic                  side;
    logic [RALLY_BITS-1:0] rally_number;
    logic [POS_BITS-1:0]   position;
    logic [X_BITS-1:0]     out_x;
    logic [DEPTH_BITS-1:0] out_depth;
    logic                  impact;
    logic                  closes_rally;
    logic                  rally_without_impact;
  } result_t;

  // all results caused by one item, slot 0 first
  typedef struct packed {
    logic [CNT_BITS-1:0]       count;
    result_t [SLOTS-1:0]       slot;
  } bundle_t;

  function automatic logic [RALLY_BITS-1:0] sat_rally(input logic [RALLY_BITS-1:0] v);
    sat_rally = (v >= RALLY_BITS'(RALLY_LIMIT)) ? RALLY_BITS'(RALLY_LIMIT) : v + 1'b1;
  endfunction

  function automatic logic [POS_BITS-1:0] sat_pos(input logic [POS_BITS-1:0] v);
    sat_pos = (v >= POS_BITS'(POINT_LIMIT)) ? POS_BITS'(POINT_LIMIT) : v + 1'b1;
  endfunction

endpackage

/* src/brc_ifs.sv */
// ----------------------------------------------------------------------------
// brc channel interfaces
// Valid/ready channels for ball points, classified results and register
// writes.
// ----------------------------------------------------------------------------
interface brc_in_if;
  logic                           valid;
  logic                           ready;
  logic [brc_pkg::X_BITS-1:0]     pos_x;
  logic [brc_pkg::DEPTH_BITS-1:0] depth;
  logic                           final_point;

  modport source (output valid, pos_x, depth, final_point, input ready);
  modport sink (input valid, pos_x, depth, final_point, output ready);
endinterface

interface brc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           side;
  logic [brc_pkg::RALLY_BITS-1:0] rally_number;
  logic [brc_pkg::POS_BITS-1:0]   position;
  logic [brc_pkg::X_BITS-1:0]     out_x;
  logic [brc_pkg::DEPTH_BITS-1:0] out_depth;
  logic                           impact;
  logic                           closes_rally;
  logic                           rally_without_impact;
  logic                           last_of_run;

  modport source (output valid, side, rally_number, position, out_x, out_depth, impact,
                  closes_rally, rally_without_impact, last_of_run, input ready);
  modport sink (input valid, side, rally_number, position, out_x, out_depth, impact,
                closes_rally, rally_without_impact, last_of_run, output ready);
endinterface

interface brc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [brc_pkg::CFG_IDX_BITS-1:0] index;
  logic [brc_pkg::DEPTH_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/ball_track_rally_impact_classifier.sv */
// ----------------------------------------------------------------------------
// ball_track_rally_impact_classifier: rally and impact classifier
// Classifies tracked ball points by direction into rallies of two sides and
// flags impact points by depth.
// ----------------------------------------------------------------------------
// A point can be accepted in every cycle while the two-entry bundle queue has
// room; each point is classified in the cycle it is accepted and causes zero
// to three results, which leave one per cycle from the output register while
// the output is ready. The first result of a point passes the queue write,
// then the sequencer load, then the output register before it is presented
// on the output. Threshold registers are always ready and take effect on the
// next point.
module ball_track_rally_impact_classifier (
  input  logic       clk,
  input  logic       rst,
  brc_in_if.sink     in_ch,
  brc_out_if.source  out_ch,
  brc_cfg_if.sink    cfg
);

  brc_pkg::thresholds_t thr;
  logic                 push;
  brc_pkg::bundle_t     push_bundle;
  logic                 q_ready;
  logic                 q_valid;
  brc_pkg::bundle_t     q_data;
  logic                 pop;
  logic                 cfg_write;

  // threshold registers
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.high <= brc_pkg::DEPTH_HIGH_RESET;
      thr.low  <= brc_pkg::DEPTH_LOW_RESET;
    end else if (cfg_write) begin
      unique case (cfg.index)
        brc_pkg::REG_DEPTH_HIGH: thr.high <= cfg.data;
        brc_pkg::REG_DEPTH_LOW:  thr.low  <= cfg.data;
        default: ;
      endcase
    end
  end

  brc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .thr     (thr),
    .q_ready (q_ready),
    .push    (push),
    .bundle  (push_bundle)
  );

  brc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_bundle),
    .ready (q_ready),
    .valid (q_valid),
    .rdata (q_data),
    .pop   (pop)
  );

  brc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  // a bundle is only pushed for an accepted point, and never into a full queue
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> (in_ch.valid && in_ch.ready && q_ready))
    else $error("bundle pushed without an accepted point");

  // the sequencer only pops a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

  // a high threshold write lands in the register
  a_cfg_high: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg.index == brc_pkg::REG_DEPTH_HIGH) |=> (thr.high == $past(cfg.data)))
    else $error("high threshold write lost");

  // a low threshold write lands in the register
  a_cfg_low: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg.index == brc_pkg::REG_DEPTH_LOW) |=> (thr.low == $past(cfg.data)))
    else $error("low threshold write lost");

endmodule

/* src/brc_front.sv */
// ----------------------------------------------------------------------------
// brc_front: point classifier
// Holds the previous point and rally state, classifies the held point when
// its successor arrives and pushes the results of that item as one bundle.
// ----------------------------------------------------------------------------
module brc_front (
  input  logic                 clk,
  input  logic                 rst,
  brc_in_if.sink               in_ch,
  input  brc_pkg::thresholds_t thr,
  input  logic                 q_ready,
  output logic                 push,
  output brc_pkg::bundle_t     bundle
);

  logic [brc_pkg::X_BITS-1:0]     held_x;
  logic [brc_pkg::DEPTH_BITS-1:0] held_depth;
  logic [brc_pkg::DEPTH_BITS-1:0] older_depth;
  logic [1:0]                     points_seen;
  logic                           moving_rising;
  logic                           moving_falling;
  logic [brc_pkg::RALLY_BITS-1:0] rally_a;
  logic [brc_pkg::RALLY_BITS-1:0] rally_b;
  logic [brc_pkg::POS_BITS-1:0]   count_a;
  logic [brc_pkg::POS_BITS-1:0]   count_b;
  logic                           impact_seen_a;
  logic                           impact_seen_b;

  logic                           accept;
  logic                           moved;
  logic                           rising;
  logic                           other_moving;
  logic [brc_pkg::RALLY_BITS-1:0] own_rally;
  logic [brc_pkg::RALLY_BITS-1:0] other_rally;
  logic [brc_pkg::POS_BITS-1:0]   own_count;
  logic [brc_pkg::POS_BITS-1:0]   other_count;
  logic [brc_pkg::POS_BITS-1:0]   count_after;
  logic                           other_seen;
  logic                           imp_main;
  logic                           imp_fin;
  brc_pkg::result_t               r_close;
  brc_pkg::result_t               r_main;
  brc_pkg::result_t               r_fin;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;

  // direction against the held point
  assign moved        = (points_seen != 2'd0) && (in_ch.pos_x != held_x);
  assign rising       = held_x < in_ch.pos_x;
  assign other_moving = rising ? moving_falling : moving_rising;
  assign own_rally    = rising ? rally_a : rally_b;
  assign other_rally  = rising ? rally_b : rally_a;
  assign own_count    = rising ? count_a : count_b;
  assign other_count  = rising ? count_b : count_a;
  assign other_seen   = rising ? impact_seen_b : impact_seen_a;
  assign count_after  = brc_pkg::sat_pos(own_count);

  // impact tests: high threshold, or local peak over the low threshold
  assign imp_main = (held_depth > thr.high) ||
                    (points_seen[1] && (held_depth > thr.low) &&
                     (held_depth > older_depth) && (held_depth > in_ch.depth));
  assign imp_fin  = in_ch.depth > thr.high;

  // the three candidate results
  always_comb begin
    r_close.side                 = rising ? brc_pkg::SIDE_B : brc_pkg::SIDE_A;
    r_close.rally_number         = other_rally;
    r_close.position             = other_count;
    r_close.out_x                = held_x;
    r_close.out_depth            = held_depth;
    r_close.impact               = 1'b0;
    r_close.closes_rally         = 1'b1;
    r_close.rally_without_impact = !other_seen;

    r_main.side                  = rising ? brc_pkg::SIDE_A : brc_pkg::SIDE_B;
    r_main.rally_number          = own_rally;
    r_main.position              = own_count;
    r_main.out_x                 = held_x;
    r_main.out_depth             = held_depth;
    r_main.impact                = imp_main;
    r_main.closes_rally          = 1'b0;
    r_main.rally_without_impact  = 1'b0;

    r_fin.side                   = r_main.side;
    r_fin.rally_number           = own_rally;
    r_fin.position               = count_after;
    r_fin.out_x                  = in_ch.pos_x;
    r_fin.out_depth              = in_ch.depth;
    r_fin.impact                 = imp_fin;
    r_fin.closes_rally           = 1'b0;
    r_fin.rally_without_impact   = 1'b0;
  end

  // pack results in order, closing result first when present
  always_comb begin
    bundle.slot[0] = other_moving ? r_close : r_main;
    bundle.slot[1] = other_moving ? r_main : r_fin;
    bundle.slot[2] = r_fin;
    bundle.count   = brc_pkg::CNT_BITS'(other_moving) + 2'd1 +
                     brc_pkg::CNT_BITS'(in_ch.final_point);
  end

  assign push = accept && moved;

  // rally state update
  always_ff @(posedge clk) begin
    if (rst || (accept && in_ch.final_point)) begin
      held_x         <= '0;
      held_depth     <= '0;
      older_depth    <= '0;
      points_seen    <= 2'd0;
      moving_rising  <= 1'b0;
      moving_falling <= 1'b0;
      rally_a        <= '0;
      rally_b        <= '0;
      count_a        <= '0;
      count_b        <= '0;
      impact_seen_a  <= 1'b0;
      impact_seen_b  <= 1'b0;
    end else if (accept) begin
      if (moved && rising) begin
        if (moving_falling) begin
          rally_b        <= brc_pkg::sat_rally(rally_b);
          count_b        <= '0;
          impact_seen_b  <= 1'b0;
          moving_falling <= 1'b0;
        end
        count_a       <= count_after;
        impact_seen_a <= impact_seen_a | imp_main;
        moving_rising <= 1'b1;
      end else if (moved) begin
        if (moving_rising) begin
          rally_a       <= brc_pkg::sat_rally(rally_a);
          count_a       <= '0;
          impact_seen_a <= 1'b0;
          moving_rising <= 1'b0;
        end
        count_b        <= count_after;
        impact_seen_b  <= impact_seen_b | imp_main;
        moving_falling <= 1'b1;
      end
      older_depth <= held_depth;
      held_x      <= in_ch.pos_x;
      held_depth  <= in_ch.depth;
      points_seen <= points_seen[1] ? 2'd2 : points_seen + 2'd1;
    end
  end

endmodule

/* src/brc_queue.sv */
// ----------------------------------------------------------------------------
// brc_queue: bundle queue
// Two-entry queue of result bundles between the classifier and the result
// sequencer.
// ----------------------------------------------------------------------------
module brc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  brc_pkg::bundle_t wdata,
  output logic             ready,
  output logic             valid,
  output brc_pkg::bundle_t rdata,
  input  logic             pop
);

  brc_pkg::bundle_t                entries [brc_pkg::QUEUE_DEPTH];
  logic [brc_pkg::PTR_BITS-1:0]    wr_ptr;
  logic [brc_pkg::PTR_BITS-1:0]    rd_ptr;
  logic [brc_pkg::FILL_BITS-1:0]   fill;

  assign ready = fill != brc_pkg::FILL_BITS'(brc_pkg::QUEUE_DEPTH);
  assign valid = fill != '0;
  assign rdata = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* src/brc_back.sv */
// ----------------------------------------------------------------------------
// brc_back: result sequencer
// Takes one bundle at a time from the queue and sends its results one per
// cycle unless stalled, via an output register; marks each item's last result.
// ----------------------------------------------------------------------------
module brc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  brc_pkg::bundle_t q_data,
  output logic             pop,
  brc_out_if.source        out_ch
);

  brc_pkg::bundle_t            cur;
  logic                        cur_valid;
  logic [brc_pkg::CNT_BITS-1:0] idx;
  brc_pkg::result_t            out_res;
  logic                        out_last;
  logic                        out_valid;

  logic                        load_out;
  logic                        last;
  logic                        cur_free;

  assign load_out = cur_valid && (!out_valid || out_ch.ready);
  assign last     = idx == (cur.count - 1'b1);
  assign cur_free = !cur_valid || (load_out && last);
  assign pop      = q_valid && cur_free;

  // current bundle and slot index
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (load_out && last) begin
      cur_valid <= 1'b0;
    end else if (load_out) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res  <= cur.slot[idx];
      out_last <= last;
    end
  end

  assign out_ch.valid                = out_valid;
  assign out_ch.side                 = out_res.side;
  assign out_ch.rally_number         = out_res.rally_number;
  assign out_ch.position             = out_res.position;
  assign out_ch.out_x                = out_res.out_x;
  assign out_ch.out_depth            = out_res.out_depth;
  assign out_ch.impact               = out_res.impact;
  assign out_ch.closes_rally         = out_res.closes_rally;
  assign out_ch.rally_without_impact = out_res.rally_without_impact;
  assign out_ch.last_of_run          = out_last;

endmodule
